// ----- src/bnpl_pkg.sv -----
// ---------------------------------------------------------------------------
// bnpl_pkg: shared types and codes for the bounded nearest points list
// Beat payloads of the request and response channels, the stored entry
// and the control group that drives the row of list cells.
// ---------------------------------------------------------------------------
package bnpl_pkg;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic CSR_SIZE_LIMIT = 1'b0;
   localparam logic CSR_DIST_LIMIT = 1'b1;

   localparam logic [4:0]  SIZE_LIMIT_RESET = 5'd16;
   localparam logic [31:0] DIST_LIMIT_RESET = 32'hFFFF_FFFF;

   typedef struct packed {
      logic               op;
      logic [31:0]        point_id;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [31:0]        point_distance;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic               entry_valid;
      logic [31:0]        entry_id;
      logic signed [31:0] entry_x;
      logic signed [31:0] entry_y;
      logic signed [31:0] entry_z;
      logic [31:0]        entry_distance;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        id;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [31:0]        distance;
   } entry_type;

   typedef struct packed {
      logic check;
      logic insert;
      logic rotate;
   } cell_ctl_type;

endpackage

// ----- src/bnpl_cell.sv -----
// ---------------------------------------------------------------------------
// bnpl_cell: one slot of the sorted list
// Holds one entry, compares it against the broadcast candidate; an insert
// loads the candidate or left entry, a read rotation the right or head entry.
// ---------------------------------------------------------------------------
module bnpl_cell (
   input  logic                  clock,
   input  bnpl_pkg::cell_ctl_type ctl,
   input  bnpl_pkg::entry_type    cand,
   input  bnpl_pkg::entry_type    left_entry,
   input  bnpl_pkg::entry_type    right_entry,
   input  bnpl_pkg::entry_type    head_entry,
   input  logic                  occupied,
   input  logic                  first,
   input  logic                  left_gt,
   input  logic                  take_head,
   output bnpl_pkg::entry_type    entry,
   output logic                  gt,
   output logic                  dup,
   output logic                  shift
);
   import bnpl_pkg::*;

   entry_type entry_ff, entry_in;
   logic      gt_ff, gt_in;
   logic      dup_ff, dup_in;

   // A slot moves when it is empty or holds a farther entry than the candidate.
   assign shift = gt_ff || !occupied;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert && shift) begin
         entry_in = (first || !left_gt) ? cand : left_entry;
      end else if (ctl.rotate) begin
         entry_in = take_head ? head_entry : right_entry;
      end
   end

   always_comb begin
      gt_in  = gt_ff;
      dup_in = dup_ff;
      if (ctl.check) begin
         gt_in  = occupied && (entry_ff.distance > cand.distance);
         dup_in = occupied && ((entry_ff.distance == cand.distance) ||
                  ((entry_ff.x == cand.x) && (entry_ff.y == cand.y) &&
                   (entry_ff.z == cand.z)));
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      gt_ff    <= gt_in;
      dup_ff   <= dup_in;
   end

   assign entry = entry_ff;
   assign gt    = gt_ff;
   assign dup   = dup_ff;

endmodule

// ----- src/bounded_nearest_points_list.sv -----
// ---------------------------------------------------------------------------
// bounded_nearest_points_list: sorted list of the nearest candidate points
// Up to MAX_ENTRIES points are kept in ascending distance in a row of cells.
//
// Request beats carry an add or a read. An add presents its single response
// beat from ST_DECIDE: ST_CHECK first broadcasts the candidate to every cell
// for the distance and duplicate compares, then ST_DECIDE decides and shifts
// the farther entries one cell to the right while the candidate drops in.
// A read emits one beat per entry, nearest first, with last on the final
// one; the list rotates one cell per beat through cell 0. An empty list
// answers with one beat. One request is worked on at a time; the next is
// taken once the previous one has handed its final beat to the response
// register. The response register holds a beat while rsp_ready is low; the
// states that emit a beat then wait and the list does not move. Configuration
// is written through the csr channel, which is always ready. Reset empties
// the list and restores a size limit of 16 and a distance limit of all ones;
// no clearing pass is needed.
// ---------------------------------------------------------------------------
module bounded_nearest_points_list #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bnpl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bnpl_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [31:0]       csr_data
);
   import bnpl_pkg::*;

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int SW = (CW > 5) ? CW : 5;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CHECK  = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_READ   = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic [4:0]    size_limit_ff, size_limit_in;
   logic [31:0]   max_dist_ff, max_dist_in;
   entry_type     cand_ff, cand_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   cell_ctl_type           ctl;
   entry_type              cell_entry [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] gt_vec, dup_vec, shift_vec;

   logic          req_fire, out_free;
   logic [SW-1:0] size_wide;
   logic [CW-1:0] cap, cnt_m1, kept, kept_m1;
   logic [CW:0]   cnt_p1;
   logic          full, last_gt, reject, accepted;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // Capacity is the size limit bounded by the number of cells.
   assign size_wide = SW'(size_limit_ff);
   assign cap = (size_wide > SW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(size_wide);

   assign cnt_m1  = count_ff - CW'(1);
   assign cnt_p1  = {1'b0, count_ff} + (CW + 1)'(1);
   assign kept    = (cnt_p1 > {1'b0, cap}) ? cap : CW'(cnt_p1);
   assign kept_m1 = kept - CW'(1);
   assign full    = (count_ff >= cap);
   assign last_gt = (count_ff != '0) && gt_vec[cnt_m1[IW-1:0]];

   // A full list only takes a point that lands ahead of its last entry.
   assign reject = (cap == '0) || (cand_ff.distance > max_dist_ff) || (|dup_vec) ||
                   (full && !last_gt);
   assign accepted = !reject && shift_vec[kept_m1[IW-1:0]];

   assign ctl.check  = (state_ff == ST_CHECK);
   assign ctl.insert = (state_ff == ST_DECIDE) && out_free && !reject;
   assign ctl.rotate = (state_ff == ST_READ) && out_free && (count_ff != '0);

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      entry_type left_e, right_e;
      logic      left_g;

      if (i == 0) begin : g_head
         assign left_e = cand_ff;
         assign left_g = 1'b0;
      end else begin : g_body
         assign left_e = cell_entry[i-1];
         assign left_g = gt_vec[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_tail
         assign right_e = cell_entry[0];
      end else begin : g_inner
         assign right_e = cell_entry[i+1];
      end

      bnpl_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .cand        (cand_ff),
         .left_entry  (left_e),
         .right_entry (right_e),
         .head_entry  (cell_entry[0]),
         .occupied    (CW'(i) < count_ff),
         .first       (i == 0),
         .left_gt     (left_g),
         .take_head   (CW'(i) == cnt_m1),
         .entry       (cell_entry[i]),
         .gt          (gt_vec[i]),
         .dup         (dup_vec[i]),
         .shift       (shift_vec[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      cand_in      = cand_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cand_in.id       = req_data.point_id;
               cand_in.x        = req_data.point_x;
               cand_in.y        = req_data.point_y;
               cand_in.z        = req_data.point_z;
               cand_in.distance = req_data.point_distance;
               remain_in        = count_ff;
               state_in         = (req_data.op == OP_READ) ? ST_READ : ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (out_free) begin
               rsp_in       = '0;
               rsp_in.accepted = accepted;
               rsp_in.last  = 1'b1;
               rsp_valid_in = 1'b1;
               if (!reject) begin
                  count_in = kept;
               end
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (out_free) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               if (count_ff == '0) begin
                  rsp_in.last = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  rsp_in.entry_valid    = 1'b1;
                  rsp_in.entry_id       = cell_entry[0].id;
                  rsp_in.entry_x        = cell_entry[0].x;
                  rsp_in.entry_y        = cell_entry[0].y;
                  rsp_in.entry_z        = cell_entry[0].z;
                  rsp_in.entry_distance = cell_entry[0].distance;
                  rsp_in.last           = (remain_ff == CW'(1));
                  remain_in             = remain_ff - CW'(1);
                  if (remain_ff == CW'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      size_limit_in = size_limit_ff;
      max_dist_in   = max_dist_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SIZE_LIMIT: size_limit_in = csr_data[4:0];
            CSR_DIST_LIMIT: max_dist_in   = csr_data;
            default: begin
               size_limit_in = size_limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         remain_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         size_limit_ff <= SIZE_LIMIT_RESET;
         max_dist_ff   <= DIST_LIMIT_RESET;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         remain_ff     <= remain_in;
         rsp_valid_ff  <= rsp_valid_in;
         size_limit_ff <= size_limit_in;
         max_dist_ff   <= max_dist_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- src/bnpl_checker.sv -----
// ---------------------------------------------------------------------------
// bnpl_checker: port-level checks for the bounded nearest points list
// Watches the request and response channels of the top level over time.
// ---------------------------------------------------------------------------
module bnpl_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bnpl_pkg::rsp_type rsp_data
);
   import bnpl_pkg::*;

   // A response beat that waits for the receiver keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   // Accepted add results are single beats and never report an entry.
   a_add_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.accepted |-> rsp_data.last && !rsp_data.entry_valid)
      else $error("accepted add beat malformed");

   // One request at a time: a request beat is never followed at once by another.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the previous one is in progress");

   // Reset leaves no response pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind bounded_nearest_points_list bnpl_checker u_checker (.*);
